@@ sv/ssh_pkg.sv @@
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared types and constants for the size snap block: register indexes,
// reset values, preset table limits and the controller/datapath interface.
// ----------------------------------------------------------------------------
package ssh_pkg;

  // Preset registers in the config map, and the usable limit applied on top
  localparam int PRESET_REGS = 4;
  localparam int MAX_PRESETS = 4;
  localparam int IDX_W       = (PRESET_REGS > 1) ? $clog2(PRESET_REGS) : 1;
  localparam int CNT_W       = 3;   // width of preset_count register
  localparam int THR_W       = 12;
  localparam int DIM_W       = 16;
  localparam int PRE_W       = 32;
  localparam int CFG_IDX_W   = 3;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_SNAP_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_DISTANCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_COUNT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_A         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_B         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_C         = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESET_D         = 3'd6;

  // Reset values
  localparam logic [THR_W-1:0] RST_SNAP_THRESHOLD   = 12'd24;
  localparam logic [THR_W-1:0] RST_RELEASE_DISTANCE = 12'd32;
  localparam logic [CNT_W-1:0] RST_PRESET_COUNT     = 3'd3;
  localparam logic [PRE_W-1:0] RST_PRESET_A         = 32'd39322400;  // 800x600
  localparam logic [PRE_W-1:0] RST_PRESET_B         = 32'd50332672;  // 1024x768
  localparam logic [PRE_W-1:0] RST_PRESET_C         = 32'd47187200;  // 1280x720
  localparam logic [PRE_W-1:0] RST_PRESET_D         = 32'd0;

  typedef logic [PRESET_REGS-1:0][PRE_W-1:0] preset_arr_t;

  // Controller -> datapath
  typedef struct packed {
    logic             load_in;
    logic             clr_best;
    logic             mul;
    logic             diff;
    logic             eval;
    logic             decide;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } ssh_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic             loop_go;   // incoming word is eligible and presets in use
    logic [CNT_W-1:0] n_use;     // usable preset count
    logic             out_free;  // output register can take a word
  } ssh_sts_t;

endpackage

@@ sv/ssh_ctrl.sv @@
// ----------------------------------------------------------------------------
// ssh_ctrl
// Sequencer: walks the usable presets (multiply, difference, evaluate each),
// then decides engagement and loads the output register.
// ----------------------------------------------------------------------------
module ssh_ctrl
  import ssh_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  ssh_sts_t sts,
  output ssh_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_DIFF   = 6'b000100,
    S_EVAL   = 6'b001000,
    S_DECIDE = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             last_idx;

  assign last_idx = (CNT_W'(idx_r) + CNT_W'(1)) == sts.n_use;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    cmd          = '0;
    cmd.idx      = idx_r;
    in_ready     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in  = 1'b1;
          cmd.clr_best = 1'b1;
          idx_nxt      = '0;
          state_nxt    = sts.loop_go ? S_MUL : S_DECIDE;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (last_idx) begin
          state_nxt = S_DECIDE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = S_MUL;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted word did not start processing");

  a_out_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && !sts.out_free) |=> (state_r == S_OUT))
    else $error("result dropped while output register busy");

  a_eval_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (CNT_W'(idx_r) < sts.n_use))
    else $error("preset index beyond usable count");

endmodule

@@ sv/ssh_dp.sv @@
// ----------------------------------------------------------------------------
// ssh_dp
// Datapath: input capture, per-preset distance and ratio test, best-match
// tracking, engagement/hold state, anchoring and the output register.
// ----------------------------------------------------------------------------
module ssh_dp
  import ssh_pkg::*;
#(
  parameter int PRESET_LIMIT = MAX_PRESETS
)
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  ssh_cmd_t                cmd,
  output ssh_sts_t                sts,
  // configuration
  input  logic [THR_W-1:0]        snap_threshold,
  input  logic [THR_W-1:0]        release_distance,
  input  logic [CNT_W-1:0]        preset_count,
  input  preset_arr_t             presets,
  // input word
  input  logic                    in_snap_eligible,
  input  logic                    in_session_start,
  input  logic signed [DIM_W-1:0] in_box_x,
  input  logic signed [DIM_W-1:0] in_box_y,
  input  logic [DIM_W-1:0]        in_box_w,
  input  logic [DIM_W-1:0]        in_box_h,
  input  logic [1:0]              in_grabbed_corner,
  input  logic                    in_ratio_locked,
  input  logic [DIM_W-1:0]        in_begin_w,
  input  logic [DIM_W-1:0]        in_begin_h,
  // result word
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DIM_W:0]   out_x,
  output logic signed [DIM_W:0]   out_y,
  output logic [DIM_W-1:0]        out_w,
  output logic [DIM_W-1:0]        out_h,
  output logic                    out_snapped
);

  localparam int SCL_W = 2 * DIM_W + 10;  // |a-b| * 1000 fits in 42 bits

  // captured word
  logic                    elig_r, start_r, locked_r;
  logic signed [DIM_W-1:0] bx_r, by_r;
  logic [DIM_W-1:0]        bw_r, bh_r, sw_r, sh_r;
  logic [1:0]              corner_r;

  // per-preset pipeline
  logic [2*DIM_W-1:0]      prod_a_r, prod_b_r, prod_p_r;
  logic [SCL_W-1:0]        scaled_r;
  logic [DIM_W-1:0]        dw_r, dh_r;

  // search results
  logic                    found_r, any_valid_r;
  logic [THR_W-1:0]        best_dist_r;
  logic [DIM_W-1:0]        best_w_r, best_h_r;

  // hold state
  logic                    engaged_r, engaged_nxt;
  logic [DIM_W-1:0]        held_w_r, held_h_r;
  logic                    snap_r, snap_nxt;

  // output register
  logic                    out_valid_r;

  logic [CNT_W-1:0]        n_use;
  logic [DIM_W-1:0]        pw, ph, dw, dh, cheb;
  logic [2*DIM_W-1:0]      dabs;
  logic [SCL_W-1:0]        dext;
  logic                    usable, in_rng, ratio_ok, better;
  logic [THR_W-1:0]        hyst;
  logic                    drift, eng0;
  logic [DIM_W+1:0]        ax, ay;

  // usable count: min(preset_count, PRESET_LIMIT, PRESET_REGS)
  always_comb begin
    n_use = preset_count;
    if (int'(n_use) > PRESET_LIMIT)  n_use = CNT_W'(PRESET_LIMIT);
    if (int'(n_use) > PRESET_REGS)   n_use = CNT_W'(PRESET_REGS);
  end

  assign sts.loop_go  = in_snap_eligible && (n_use != '0);
  assign sts.n_use    = n_use;
  assign sts.out_free = !out_valid_r || out_ready;

  assign pw = presets[cmd.idx][DIM_W-1:0];
  assign ph = presets[cmd.idx][PRE_W-1:DIM_W];

  assign dw   = (bw_r > pw) ? (bw_r - pw) : (pw - bw_r);
  assign dh   = (bh_r > ph) ? (bh_r - ph) : (ph - bh_r);
  assign dabs = (prod_a_r > prod_b_r) ? (prod_a_r - prod_b_r) : (prod_b_r - prod_a_r);
  assign dext = SCL_W'(dabs);

  // evaluate stage
  assign usable   = (pw != '0) && (ph != '0);
  assign in_rng   = (dw_r <= DIM_W'(snap_threshold)) && (dh_r <= DIM_W'(snap_threshold));
  assign ratio_ok = !locked_r ||
                    ((sw_r != '0) && (sh_r != '0) && (scaled_r <= SCL_W'(prod_p_r)));
  assign cheb     = (dw_r > dh_r) ? dw_r : dh_r;
  assign better   = !found_r || (cheb[THR_W-1:0] < best_dist_r);

  // decide stage
  assign hyst  = (release_distance > snap_threshold) ? release_distance : snap_threshold;
  assign eng0  = engaged_r && !start_r;
  assign drift = (((bw_r > held_w_r) ? (bw_r - held_w_r) : (held_w_r - bw_r)) > DIM_W'(hyst))
              || (((bh_r > held_h_r) ? (bh_r - held_h_r) : (held_h_r - bh_r)) > DIM_W'(hyst));

  always_comb begin
    engaged_nxt = engaged_r;
    snap_nxt    = 1'b0;
    if (elig_r) begin
      if ((snap_threshold == '0) || !any_valid_r) begin
        engaged_nxt = 1'b0;
      end else if (found_r) begin
        engaged_nxt = 1'b1;
      end else if (eng0 && drift) begin
        engaged_nxt = 1'b0;
      end else begin
        engaged_nxt = eng0;
      end
      snap_nxt = engaged_nxt && (snap_threshold != '0) && any_valid_r;
    end
  end

  // anchor the edge that is not dragged
  assign ax = {{2{bx_r[DIM_W-1]}}, bx_r} + {2'b00, bw_r} - {2'b00, held_w_r};
  assign ay = {{2{by_r[DIM_W-1]}}, by_r} + {2'b00, bh_r} - {2'b00, held_h_r};

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      elig_r   <= in_snap_eligible;
      start_r  <= in_session_start;
      bx_r     <= in_box_x;
      by_r     <= in_box_y;
      bw_r     <= in_box_w;
      bh_r     <= in_box_h;
      corner_r <= in_grabbed_corner;
      locked_r <= in_ratio_locked;
      sw_r     <= in_begin_w;
      sh_r     <= in_begin_h;
    end
    if (cmd.mul) begin
      prod_a_r <= ph * sw_r;
      prod_b_r <= sh_r * pw;
      prod_p_r <= pw * sw_r;
    end
    if (cmd.diff) begin
      scaled_r <= (dext << 10) - (dext << 4) - (dext << 3);  // x1000
      dw_r     <= dw;
      dh_r     <= dh;
    end
    if (cmd.eval && usable && in_rng && ratio_ok && better) begin
      best_dist_r <= cheb[THR_W-1:0];
      best_w_r    <= pw;
      best_h_r    <= ph;
    end
    if (cmd.out_load) begin
      if (snap_r) begin
        out_w <= held_w_r;
        out_h <= held_h_r;
        out_x <= corner_r[0] ? {bx_r[DIM_W-1], bx_r} : ax[DIM_W:0];
        out_y <= corner_r[1] ? {by_r[DIM_W-1], by_r} : ay[DIM_W:0];
      end else begin
        out_w <= bw_r;
        out_h <= bh_r;
        out_x <= {bx_r[DIM_W-1], bx_r};
        out_y <= {by_r[DIM_W-1], by_r};
      end
      out_snapped <= snap_r;
    end
  end

  // control and hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= 1'b0;
      any_valid_r <= 1'b0;
      engaged_r   <= 1'b0;
      held_w_r    <= '0;
      held_h_r    <= '0;
      snap_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_best) begin
        found_r     <= 1'b0;
        any_valid_r <= 1'b0;
      end else if (cmd.eval) begin
        if (usable) any_valid_r <= 1'b1;
        if (usable && in_rng && ratio_ok) found_r <= 1'b1;
      end
      if (cmd.decide) begin
        engaged_r <= engaged_nxt;
        snap_r    <= snap_nxt;
        if (elig_r && (snap_threshold != '0) && any_valid_r && found_r) begin
          held_w_r <= best_w_r;
          held_h_r <= best_h_r;
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  a_found_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> any_valid_r)
    else $error("match recorded without a usable preset");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("output valid without a load");

  a_snap_needs_engage: assert property (@(posedge clk) disable iff (!rst_n)
    snap_r |-> engaged_r)
    else $error("snap flagged while not engaged");

endmodule

@@ sv/size_snap_with_hysteresis.sv @@
// ----------------------------------------------------------------------------
// size_snap_with_hysteresis
// Snaps a dragged window size to the nearest preset within a threshold and
// holds it until the size drifts past the release distance.
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+---------------------------------------------
//   in      | in_valid/in_ready   | snap_eligible, session_start, box x/y/w/h,
//           |                     | grabbed_corner, ratio_locked, begin_w/h
//   out     | out_valid/out_ready | out_x, out_y, out_w, out_h, out_snapped
//   cfg     | cfg_we              | cfg_index, cfg_wdata (write only)
//
// Sequence: an accepted word gets, for each usable preset (0..4 for an
//   eligible word, none for an ineligible one), multiply, difference and
//   evaluate steps on one shared set of three 16x16 multipliers, then the
//   decide step and the load into the output register. The sequencer
//   returns to idle after the load, so a new word is taken only once the
//   previous one has been loaded into the output register.
// Reset: rst_n synchronous, active low; config returns to defaults and the
//   engagement/hold state clears.
// Stalls: a finished word waits in the output register; the next word is
//   accepted meanwhile, and the sequencer stalls only at its own output load.
//
module size_snap_with_hysteresis
  import ssh_pkg::*;
#(
  parameter int PRESET_LIMIT = MAX_PRESETS
)
(
  input  logic                        clk,
  input  logic                        rst_n,
  // config write port
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [PRE_W-1:0]            cfg_wdata,
  // input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_snap_eligible,
  input  logic                        in_session_start,
  input  logic signed [DIM_W-1:0]     in_box_x,
  input  logic signed [DIM_W-1:0]     in_box_y,
  input  logic [DIM_W-1:0]            in_box_w,
  input  logic [DIM_W-1:0]            in_box_h,
  input  logic [1:0]                  in_grabbed_corner,
  input  logic                        in_ratio_locked,
  input  logic [DIM_W-1:0]            in_begin_w,
  input  logic [DIM_W-1:0]            in_begin_h,
  // result channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DIM_W:0]       out_x,
  output logic signed [DIM_W:0]       out_y,
  output logic [DIM_W-1:0]            out_w,
  output logic [DIM_W-1:0]            out_h,
  output logic                        out_snapped
);

  // Config registers
  logic [THR_W-1:0] snap_threshold_r;
  logic [THR_W-1:0] release_distance_r;
  logic [CNT_W-1:0] preset_count_r;
  preset_arr_t      presets_r;

  ssh_cmd_t cmd;
  ssh_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_threshold_r   <= RST_SNAP_THRESHOLD;
      release_distance_r <= RST_RELEASE_DISTANCE;
      preset_count_r     <= RST_PRESET_COUNT;
      presets_r[0]       <= RST_PRESET_A;
      presets_r[1]       <= RST_PRESET_B;
      presets_r[2]       <= RST_PRESET_C;
      presets_r[3]       <= RST_PRESET_D;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SNAP_THRESHOLD:   snap_threshold_r   <= cfg_wdata[THR_W-1:0];
        CFG_RELEASE_DISTANCE: release_distance_r <= cfg_wdata[THR_W-1:0];
        CFG_PRESET_COUNT:     preset_count_r     <= cfg_wdata[CNT_W-1:0];
        CFG_PRESET_A:         presets_r[0]       <= cfg_wdata;
        CFG_PRESET_B:         presets_r[1]       <= cfg_wdata;
        CFG_PRESET_C:         presets_r[2]       <= cfg_wdata;
        CFG_PRESET_D:         presets_r[3]       <= cfg_wdata;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

  ssh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ssh_dp #(
    .PRESET_LIMIT (PRESET_LIMIT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .snap_threshold    (snap_threshold_r),
    .release_distance  (release_distance_r),
    .preset_count      (preset_count_r),
    .presets           (presets_r),
    .in_snap_eligible  (in_snap_eligible),
    .in_session_start  (in_session_start),
    .in_box_x          (in_box_x),
    .in_box_y          (in_box_y),
    .in_box_w          (in_box_w),
    .in_box_h          (in_box_h),
    .in_grabbed_corner (in_grabbed_corner),
    .in_ratio_locked   (in_ratio_locked),
    .in_begin_w        (in_begin_w),
    .in_begin_h        (in_begin_h),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_x             (out_x),
    .out_y             (out_y),
    .out_w             (out_w),
    .out_h             (out_h),
    .out_snapped       (out_snapped)
  );

endmodule
